// File: sv/rau_pkg.sv
// shared constants for the rational arithmetic unit
package rau_pkg;

    localparam int FUNC_W    = 4;
    localparam int RES_NUM_W = 34;
    localparam int RES_DEN_W = 33;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_EQ  = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_LT  = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_LE  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_GT  = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_GE  = 4'd8;

endpackage

// File: sv/rau_if.sv
// operand and result channel interfaces of the rational arithmetic unit

interface rau_in_if #(parameter int OPERAND_WIDTH = 16);
    logic                            valid;
    logic                            ready;
    logic        [3:0]               func;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    logic signed [33:0] res_num;
    logic        [32:0] res_den;
    logic               compare_true;
    logic               den_zero;

    modport source (output valid, res_num, res_den, compare_true, den_zero, input ready);
    modport sink   (input valid, res_num, res_den, compare_true, den_zero, output ready);
endinterface

// File: sv/rau_reduce.sv
// gcd reduction: binary gcd followed by two restoring divisions by the gcd
module rau_reduce #(
    parameter int IW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [IW-1:0] nm,
    input  logic [IW-1:0] dm,
    output logic          done,
    output logic [IW-1:0] nq,
    output logic [IW-1:0] dq
);
    import rau_pkg::*;

    localparam int CW = $clog2(IW);
    localparam int KW = $clog2(IW + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(IW - 1);

    typedef enum logic [2:0] {
        R_IDLE,
        R_GCD,
        R_SHIFT,
        R_DIVN,
        R_DIVD
    } rstate_t;

    rstate_t       state_reg, state_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [IW-1:0] u_reg, u_next;
    logic [IW-1:0] v_reg, v_next;
    logic [IW-1:0] g_reg, g_next;
    logic [IW-1:0] x_reg, x_next;
    logic [IW:0]   rem_reg, rem_next;
    logic [IW-1:0] ns_reg, ns_next;
    logic [IW-1:0] ds_reg, ds_next;
    logic [IW-1:0] nq_reg, nq_next;
    logic [IW-1:0] dq_reg, dq_next;

    // one restoring division step
    logic [IW:0]   rem_sh;
    logic [IW+1:0] diff;
    logic [IW:0]   rem_step;
    logic [IW-1:0] x_step;

    always_comb
    begin
        rem_sh = {rem_reg[IW-1:0], x_reg[IW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, g_reg};
        if (!diff[IW+1])
        begin
            rem_step = diff[IW:0];
            x_step   = {x_reg[IW-2:0], 1'b1};
        end
        else
        begin
            rem_step = rem_sh;
            x_step   = {x_reg[IW-2:0], 1'b0};
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        g_next     = g_reg;
        x_next     = x_reg;
        rem_next   = rem_reg;
        ns_next    = ns_reg;
        ds_next    = ds_reg;
        nq_next    = nq_reg;
        dq_next    = dq_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    u_next     = nm;
                    v_next     = dm;
                    ns_next    = nm;
                    ds_next    = dm;
                    k_next     = '0;
                    state_next = R_GCD;
                end
            end
            R_GCD:
            begin
                if (u_reg == '0 || v_reg == '0)
                begin
                    state_next = R_SHIFT;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg >= v_reg)
                begin
                    u_next = (u_reg - v_reg) >> 1;
                end
                else
                begin
                    v_next = (v_reg - u_reg) >> 1;
                end
            end
            R_SHIFT:
            begin
                g_next     = (u_reg | v_reg) << k_reg;
                x_next     = ns_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = R_DIVN;
            end
            R_DIVN:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    nq_next    = x_step;
                    x_next     = ds_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = R_DIVD;
                end
                else
                begin
                    x_next   = x_step;
                    rem_next = rem_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            R_DIVD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    dq_next    = x_step;
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    x_next   = x_step;
                    rem_next = rem_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        g_reg   <= g_next;
        x_reg   <= x_next;
        rem_reg <= rem_next;
        ns_reg  <= ns_next;
        ds_reg  <= ds_next;
        nq_reg  <= nq_next;
        dq_reg  <= dq_next;
    end

    assign done = done_reg;
    assign nq   = nq_reg;
    assign dq   = dq_reg;

endmodule

// File: sv/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
//
// usage: one operand transaction (func, a_num/a_den, b_num/b_den) goes in on
// the operands channel, one result transaction comes out on the result
// channel. ready/valid on both sides; a transaction moves when both are high.
// operands.ready is high only while the sequencer is idle; one item is
// worked on at a time through a single shared multiplier; the gcd and
// the divisions by the gcd run in the separate rau_reduce unit.
// IW = 2*OPERAND_WIDTH+1 capped at 64 (33 at default width).
// unused codes go straight to the output step; compares use the shared
// multiplier, then compare in the form step; a zero result denominator
// skips the reduction and raises den_zero; add/sub/mul/div run multiply
// steps, a binary gcd loop, then two restoring divisions by the gcd.
// a finished result sits in the output register until taken; the sequencer
// waits in its last step while the previous result is still stalled.
// reset (rst_n, asynchronous, active low) empties the output register and
// returns the sequencer to idle; no clearing pass is needed.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    operands,
    rau_out_if.source result
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int IW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FORM,
        S_MAG,
        S_RED,
        S_SIGN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   red_start;

    logic        [FUNC_W-1:0]    func_reg, func_next;
    logic signed [W:0]           a_reg, a_next, b_reg, b_next;
    logic signed [W:0]           c_reg, c_next, d_reg, d_next;
    logic signed [IW-1:0]        p_reg, p_next, q_reg, q_next, r_reg, r_next;
    logic signed [IW-1:0]        n_reg, n_next, dn_reg, dn_next;
    logic        [IW-1:0]        nm_mag, dm_mag;
    logic                        neg_reg, neg_next;
    logic signed [RES_NUM_W-1:0] rnum_reg, rnum_next;
    logic        [RES_DEN_W-1:0] rden_reg, rden_next;
    logic                        cmp_reg, cmp_next, dz_reg, dz_next;
    logic signed [RES_NUM_W-1:0] onum_reg, onum_next;
    logic        [RES_DEN_W-1:0] oden_reg, oden_next;
    logic                        ocmp_reg, ocmp_next, odz_reg, odz_next;

    logic signed [W:0]     mul_x, mul_y;
    logic signed [2*W+1:0] mul_p;
    logic signed [IW-1:0]  prod;
    logic signed [W:0]     an_ext, ad_ext, bn_ext, bd_ext;
    logic                  red_done;
    logic        [IW-1:0]  nq, dq;
    logic signed [IW:0]    nq_s;
    logic                  out_free;

    // sign extension of the incoming operands
    always_comb
    begin
        an_ext = (W + 1)'(operands.a_num);
        ad_ext = (W + 1)'(operands.a_den);
        bn_ext = (W + 1)'(operands.b_num);
        bd_ext = (W + 1)'(operands.b_den);
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_x = a_reg;
                mul_y = (func_reg == FUNC_MUL) ? c_reg : d_reg;
            end
            S_MUL2:
            begin
                mul_x = b_reg;
                mul_y = (func_reg == FUNC_MUL) ? d_reg : c_reg;
            end
            default:
            begin
                mul_x = b_reg;
                mul_y = d_reg;
            end
        endcase
    end

    assign mul_p    = mul_x * mul_y;
    assign prod     = IW'(mul_p);
    assign nq_s     = $signed({1'b0, nq});
    assign out_free = !out_valid_reg || result.ready;

    // magnitudes handed to the reduction unit at start
    assign nm_mag = n_reg[IW-1] ? IW'(-n_reg) : IW'(n_reg);
    assign dm_mag = dn_reg[IW-1] ? IW'(-dn_reg) : IW'(dn_reg);

    rau_reduce #(
        .IW (IW)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .nm    (nm_mag),
        .dm    (dm_mag),
        .done  (red_done),
        .nq    (nq),
        .dq    (dq)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        red_start      = 1'b0;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        n_next         = n_reg;
        dn_next        = dn_reg;
        neg_next       = neg_reg;
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        cmp_next       = cmp_reg;
        dz_next        = dz_reg;
        onum_next      = onum_reg;
        oden_next      = oden_reg;
        ocmp_next      = ocmp_reg;
        odz_next       = odz_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (operands.valid)
                begin
                    func_next = operands.func;
                    a_next    = operands.a_den[W-1] ? -an_ext : an_ext;
                    b_next    = operands.a_den[W-1] ? -ad_ext : ad_ext;
                    c_next    = operands.b_den[W-1] ? -bn_ext : bn_ext;
                    d_next    = operands.b_den[W-1] ? -bd_ext : bd_ext;
                    rnum_next = '0;
                    rden_next = '0;
                    cmp_next  = 1'b0;
                    dz_next   = 1'b0;
                    if (operands.func > FUNC_GE)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                p_next     = prod;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                q_next = prod;
                if (func_reg == FUNC_ADD || func_reg == FUNC_SUB)
                begin
                    state_next = S_MUL3;
                end
                else
                begin
                    state_next = S_FORM;
                end
            end
            S_MUL3:
            begin
                r_next     = prod;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                state_next = S_MAG;
                case (func_reg)
                    FUNC_ADD:
                    begin
                        n_next  = p_reg + q_reg;
                        dn_next = r_reg;
                    end
                    FUNC_SUB:
                    begin
                        n_next  = p_reg - q_reg;
                        dn_next = r_reg;
                    end
                    FUNC_MUL, FUNC_DIV:
                    begin
                        n_next  = p_reg;
                        dn_next = q_reg;
                    end
                    FUNC_EQ:
                    begin
                        cmp_next   = (p_reg == q_reg);
                        state_next = S_OUT;
                    end
                    FUNC_LT:
                    begin
                        cmp_next   = (p_reg < q_reg);
                        state_next = S_OUT;
                    end
                    FUNC_LE:
                    begin
                        cmp_next   = (p_reg <= q_reg);
                        state_next = S_OUT;
                    end
                    FUNC_GT:
                    begin
                        cmp_next   = (p_reg > q_reg);
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        cmp_next   = (p_reg >= q_reg);
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MAG:
            begin
                if (dn_reg == '0)
                begin
                    // zero denominator: unreduced numerator, flag raised
                    rnum_next  = RES_NUM_W'(n_reg);
                    dz_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next   = n_reg[IW-1] ^ dn_reg[IW-1];
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (red_start == 1'b0 && red_done)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (neg_reg && nq != '0)
                begin
                    rnum_next = RES_NUM_W'(-nq_s);
                end
                else
                begin
                    rnum_next = RES_NUM_W'(nq_s);
                end
                rden_next  = RES_DEN_W'(dq);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    onum_next      = rnum_reg;
                    oden_next      = rden_reg;
                    ocmp_next      = cmp_reg;
                    odz_next       = dz_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // kick the reduction unit on entry to the reduce step
        if (state_reg == S_MAG && dn_reg != '0)
        begin
            red_start = 1'b1;
        end
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        n_reg    <= n_next;
        dn_reg   <= dn_next;
        neg_reg  <= neg_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        cmp_reg  <= cmp_next;
        dz_reg   <= dz_next;
        onum_reg <= onum_next;
        oden_reg <= oden_next;
        ocmp_reg <= ocmp_next;
        odz_reg  <= odz_next;
    end

    assign operands.ready      = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.res_num      = onum_reg;
    assign result.res_den      = oden_reg;
    assign result.compare_true = ocmp_reg;
    assign result.den_zero     = odz_reg;

endmodule
